@@ rtl/serial_link_port_core_macros.svh @@
// Assertion macros shared by the serial link port checker.
`ifndef SERIAL_LINK_PORT_CORE_MACROS_SVH
`define SERIAL_LINK_PORT_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SLP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/slp_pkg.sv @@
// Types and constants for the serial link port.
package slp_pkg;

    localparam logic [1:0]  CMD_TICK  = 2'd0;
    localparam logic [1:0]  CMD_READ  = 2'd1;
    localparam logic [1:0]  CMD_WRITE = 2'd2;

    localparam logic [15:0] ADDR_DATA = 16'hFF01;
    localparam logic [15:0] ADDR_CTRL = 16'hFF02;

    localparam logic [7:0]  CTRL_READ_OR  = 8'h7E;
    localparam logic [7:0]  OPEN_BUS_READ = 8'hFF;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  tick_cycles;
    } t_slp_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       sent_valid;
        logic [7:0] sent_byte;
    } t_slp_rsp;

endpackage

@@ rtl/slp_engine.sv @@
// Serial port register state and per-request next-state and response logic.
module slp_engine #(
    parameter int BIT_PERIOD = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  slp_pkg::t_slp_req i_req,
    output slp_pkg::t_slp_rsp o_rsp
);
    import slp_pkg::*;

    localparam int TW = $clog2(BIT_PERIOD);
    localparam int SW = TW + 1;

    logic [7:0]    r_data,    n_data;
    logic [1:0]    r_ctrl,    n_ctrl;
    logic [3:0]    r_bits,    n_bits;
    logic [7:0]    r_latched, n_latched;
    logic [TW-1:0] r_timer,   n_timer;

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_wrap;

    assign w_sum  = {1'b0, r_timer} + SW'(i_req.tick_cycles);
    assign w_wrap = w_sum - SW'(BIT_PERIOD);

    always_comb begin
        n_data    = r_data;
        n_ctrl    = r_ctrl;
        n_bits    = r_bits;
        n_latched = r_latched;
        n_timer   = r_timer;
        o_rsp     = '0;
        case (i_req.command)
            CMD_TICK: begin
                if (r_bits != 4'd0 && r_ctrl == 2'b11) begin
                    n_timer = w_sum[TW-1:0];
                    if (w_sum >= SW'(BIT_PERIOD)) begin
                        n_timer = w_wrap[TW-1:0];
                        n_data  = {r_data[6:0], 1'b1};
                        n_bits  = r_bits - 4'd1;
                        if (r_bits == 4'd1) begin
                            // last bit: drop leftover cycles
                            n_ctrl[1]         = 1'b0;
                            n_timer           = '0;
                            o_rsp.irq_request = 1'b1;
                            o_rsp.sent_valid  = 1'b1;
                            o_rsp.sent_byte   = r_latched;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (i_req.address == ADDR_DATA) begin
                    o_rsp.read_data = r_data;
                end else if (i_req.address == ADDR_CTRL) begin
                    o_rsp.read_data = {r_ctrl[1], 6'd0, r_ctrl[0]} | CTRL_READ_OR;
                end else begin
                    o_rsp.read_data = OPEN_BUS_READ;
                end
            end
            CMD_WRITE: begin
                if (i_req.address == ADDR_DATA) begin
                    n_data = i_req.write_data;
                end else if (i_req.address == ADDR_CTRL) begin
                    n_ctrl = {i_req.write_data[7], i_req.write_data[0]};
                    if (i_req.write_data[7]) begin
                        n_bits    = BITS_PER_BYTE;
                        n_latched = r_data;
                        n_timer   = '0;
                    end else begin
                        n_bits = 4'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data    <= '0;
            r_ctrl    <= '0;
            r_bits    <= '0;
            r_latched <= '0;
            r_timer   <= '0;
        end else if (i_fire) begin
            r_data    <= n_data;
            r_ctrl    <= n_ctrl;
            r_bits    <= n_bits;
            r_latched <= n_latched;
            r_timer   <= n_timer;
        end
    end

endmodule

@@ rtl/serial_link_port_core.sv @@
// Path: a request is held in the input register, then its response in the result reg.
// Throughput: one request per cycle; the single-pass engine between the two
// registers handles any request combinationally, so only output stalls hold it.
// Reset (synchronous, active low) clears the data, control, bit count, latched
// byte and bit timer, and empties both pipeline registers.
module serial_link_port_core #(
    parameter int BIT_PERIOD = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  slp_pkg::t_slp_req i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output slp_pkg::t_slp_rsp o_rsp
);
    import slp_pkg::*;

    logic     r_in_valid;
    t_slp_req r_in_req;
    logic     r_out_valid;
    t_slp_rsp r_out_rsp;

    logic     w_out_free;
    logic     w_fire;
    t_slp_rsp w_rsp;

    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign o_req_ready = !r_in_valid || w_out_free;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out_rsp;

    slp_engine #(
        .BIT_PERIOD(BIT_PERIOD)
    ) u_engine (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_fire),
        .i_req  (r_in_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_req_ready) begin
                r_in_valid <= i_req_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_in_req <= i_req;
        end
        if (w_fire) begin
            r_out_rsp <= w_rsp;
        end
    end

endmodule

@@ rtl/slp_checker.sv @@
// Port-level checker for the serial link port, bound to the top level.
`include "serial_link_port_core_macros.svh"

module slp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_req_ready,
    input logic              o_rsp_valid,
    input logic              i_rsp_ready,
    input slp_pkg::t_slp_rsp o_rsp
);
    import slp_pkg::*;

    `SLP_ASSERT(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "response changed while stalled")
    `SLP_ASSERT(a_irq_with_sent, o_rsp_valid |-> o_rsp.irq_request == o_rsp.sent_valid, "irq and sent byte disagree")
    `SLP_ASSERT(a_sent_no_read, o_rsp_valid && o_rsp.sent_valid |-> o_rsp.read_data == 8'd0, "transfer done with read data")
    `SLP_ASSERT(a_ready_when_empty, !o_rsp_valid |-> o_req_ready, "request blocked with empty output")
    `SLP_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_rsp_valid, "response valid after reset")

endmodule

bind serial_link_port_core slp_checker u_slp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_req_ready(o_req_ready),
    .o_rsp_valid(o_rsp_valid),
    .i_rsp_ready(i_rsp_ready),
    .o_rsp      (o_rsp)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for serial_link_port_core: predicted responses, random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slp_pkg::*;

    localparam int         BIT_PERIOD  = 512;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         RANDOM_REQS = 2000;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [7:0] CTRL_START  = 8'h80;
    localparam logic [7:0] CTRL_INTCLK = 8'h01;

    class serial_port_scoreboard;
        logic [7:0] data_reg;
        logic [1:0] ctrl_bits;
        logic [3:0] bits_left;
        logic [7:0] latched;
        logic [9:0] bit_timer;
        t_slp_rsp   port_rsp_q[$];
        int         errors;

        function new();
            data_reg  = '0;
            ctrl_bits = '0;
            bits_left = '0;
            latched   = '0;
            bit_timer = '0;
            errors    = 0;
        endfunction

        function t_slp_rsp predict_port_response(t_slp_req r);
            t_slp_rsp    rsp;
            logic [10:0] t;
            rsp = '0;
            case (r.command)
                CMD_TICK: begin
                    if (bits_left != 0 && ctrl_bits == 2'b11) begin
                        t = {1'b0, bit_timer} + {3'b0, r.tick_cycles};
                        if (t >= BIT_PERIOD) begin
                            t = t - BIT_PERIOD;
                            data_reg  = {data_reg[6:0], 1'b1};
                            bits_left = bits_left - 4'd1;
                            if (bits_left == 0) begin
                                ctrl_bits[1]    = 1'b0;
                                rsp.irq_request = 1'b1;
                                rsp.sent_valid  = 1'b1;
                                rsp.sent_byte   = latched;
                                t = '0;
                            end
                        end
                        bit_timer = t[9:0];
                    end
                end
                CMD_READ: begin
                    if (r.address == ADDR_DATA)
                        rsp.read_data = data_reg;
                    else if (r.address == ADDR_CTRL)
                        rsp.read_data = CTRL_READ_OR | {ctrl_bits[1], 6'b0, ctrl_bits[0]};
                    else
                        rsp.read_data = OPEN_BUS_READ;
                end
                CMD_WRITE: begin
                    if (r.address == ADDR_DATA) begin
                        data_reg = r.write_data;
                    end else if (r.address == ADDR_CTRL) begin
                        ctrl_bits = {r.write_data[7], r.write_data[0]};
                        if (r.write_data[7]) begin
                            bits_left = BITS_PER_BYTE;
                            latched   = data_reg;
                            bit_timer = '0;
                        end else begin
                            bits_left = '0;
                        end
                    end
                end
                default: ;
            endcase
            return rsp;
        endfunction

        function void note_request(t_slp_req r);
            port_rsp_q.push_back(predict_port_response(r));
        endfunction

        task report(string what, int got, int exp_val);
            $display("%0t mismatch %s: got %0h, predicted %0h", $realtime, what, got, exp_val);
            errors++;
        endtask

        task check_response(t_slp_rsp got);
            t_slp_rsp want;
            if (port_rsp_q.size() == 0) begin
                report("unexpected response", got, 0);
                return;
            end
            want = port_rsp_q.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.irq_request !== want.irq_request)
                report("irq_request", got.irq_request, want.irq_request);
            if (got.sent_valid !== want.sent_valid)
                report("sent_valid", got.sent_valid, want.sent_valid);
            if (got.sent_byte !== want.sent_byte)
                report("sent_byte", got.sent_byte, want.sent_byte);
        endtask
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_req_valid = 1'b0;
    logic     o_req_ready;
    t_slp_req i_req = '0;
    logic     o_rsp_valid;
    logic     i_rsp_ready = 1'b0;
    t_slp_rsp o_rsp;

    serial_port_scoreboard sb = new();

    int req_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int n_reqs        = 0;
    int stall_cycles  = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;

    serial_link_port_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    function t_slp_req make_req(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wd,
                                logic [7:0] cyc);
        t_slp_req r;
        r.command     = cmd;
        r.address     = addr;
        r.write_data  = wd;
        r.tick_cycles = cyc;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_req(input t_slp_req r);
        while ($urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(r);
        n_reqs++;
        @(negedge i_clk);
    endtask

    function logic [7:0] rand_cycles();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(200, 255));
    endfunction

    function logic [15:0] rand_addr();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return ADDR_DATA;
            2:       return ADDR_CTRL;
            default: return 16'hFF00 + 16'($urandom_range(0, 3));
        endcase
    endfunction

    task run_transfer();
        int guard;
        int pick;
        send_req(make_req(CMD_WRITE, ADDR_DATA, 8'($urandom_range(0, 255)), 8'($urandom)));
        send_req(make_req(CMD_WRITE, ADDR_CTRL,
                          CTRL_START | CTRL_INTCLK | (8'($urandom) & 8'h7E), 8'($urandom)));
        guard = 0;
        while (sb.bits_left != 0 && sb.ctrl_bits == 2'b11 && guard < 200) begin
            pick = $urandom_range(0, 99);
            if (pick <= 11)
                send_req(make_req(CMD_READ, ($urandom_range(0, 1) ? ADDR_DATA : ADDR_CTRL),
                                  8'($urandom), 8'($urandom)));
            else if (pick <= 14)
                send_req(make_req(CMD_WRITE, ADDR_DATA, 8'($urandom), 8'($urandom)));
            else if (pick == 15)
                send_req(make_req(CMD_WRITE, ADDR_CTRL, 8'($urandom), 8'($urandom)));
            else
                send_req(make_req(CMD_TICK, 16'($urandom), 8'($urandom), rand_cycles()));
            guard++;
        end
        send_req(make_req(CMD_READ, ADDR_CTRL, 8'($urandom), 8'($urandom)));
    endtask

    task run_noise();
        repeat ($urandom_range(1, 6))
            send_req(make_req(2'($urandom_range(0, 3)), rand_addr(), 8'($urandom),
                              8'($urandom)));
    endtask

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            sb.check_response(o_rsp);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[serial_link_port_core] ERROR");
            $finish;
        end
    end

    initial begin
        int  phase_end;
        bit  held;
        held = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        send_req(make_req(CMD_READ, ADDR_DATA, 8'h00, 8'h00));
        send_req(make_req(CMD_READ, ADDR_CTRL, 8'h00, 8'h00));
        send_req(make_req(CMD_READ, 16'h0000, 8'h00, 8'h00));
        send_req(make_req(CMD_READ, 16'hFFFF, 8'hFF, 8'hFF));
        send_req(make_req(CMD_UNUSED, ADDR_CTRL, 8'hFF, 8'hFF));
        send_req(make_req(CMD_TICK, 16'h0000, 8'h00, 8'hFF));
        send_req(make_req(CMD_WRITE, 16'h1234, 8'hFF, 8'h00));
        send_req(make_req(CMD_WRITE, ADDR_DATA, 8'h5A, 8'h00));
        send_req(make_req(CMD_WRITE, ADDR_CTRL, 8'hFF, 8'h00));
        send_req(make_req(CMD_READ, ADDR_CTRL, 8'h00, 8'h00));
        // 16 full ticks leave 7 bits done and the last bit still pending; the next one completes
        // the byte with its leftover cycles discarded
        repeat (17) send_req(make_req(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF));
        send_req(make_req(CMD_READ, ADDR_DATA, 8'h00, 8'h00));
        send_req(make_req(CMD_READ, ADDR_CTRL, 8'h00, 8'h00));

        // random, four phases with different idle and stall rates
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin req_idle_pct = 69; rsp_stall_pct = 0;  end
                2: begin req_idle_pct = 0;  rsp_stall_pct = 69; end
                default: begin req_idle_pct = 23; rsp_stall_pct = 23; end
            endcase
            phase_end = n_reqs + RANDOM_REQS / 4;
            while (n_reqs < phase_end) begin
                if (!held && phase == 0 && n_reqs > 150) begin
                    hold_request = 1'b1;
                    held = 1'b1;
                end
                if ($urandom_range(0, 99) < 70)
                    run_transfer();
                else
                    run_noise();
            end
        end
        i_req_valid <= 1'b0;

        while (sb.port_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[serial_link_port_core] OK");
        else
            $display("[serial_link_port_core] ERROR");
        $finish;
    end
endmodule

@@ serial_link_port_core.f @@
+incdir+rtl
rtl/slp_pkg.sv
rtl/slp_engine.sv
rtl/serial_link_port_core.sv
rtl/slp_checker.sv
tb/sv/tb_top.sv
